// ===== hw/rtl/tlbm_pkg.sv =====
// Shared types, codes and constants of the tile latch bank mapper.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package tlbm_pkg;

   // Bank limits
   localparam int MAX_PRG_BANKS = 16;
   localparam int MAX_CHR_BANKS = 32;
   localparam int CHR_RAM_BANKS = 2;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int TGT_W    = 3;
   localparam int OFFSET_W = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // Bank number and bank count widths
   localparam int PRG_SEL_W   = 4;
   localparam int CHR_SEL_W   = 5;
   localparam int PRG_COUNT_W = 5;
   localparam int CHR_COUNT_W = 6;
   localparam int DVD_W       = CHR_SEL_W;
   localparam int DIV_W       = CHR_COUNT_W;
   localparam int DIV_STEPS   = DVD_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_CPU_READ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PPU_FETCH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PPU_PEEK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PPU_WRITE = 3'd4;

   // Target memories
   localparam logic [TGT_W-1:0] TGT_NONE    = 3'd0;
   localparam logic [TGT_W-1:0] TGT_PRG_ROM = 3'd1;
   localparam logic [TGT_W-1:0] TGT_PRG_RAM = 3'd2;
   localparam logic [TGT_W-1:0] TGT_CHR_ROM = 3'd3;
   localparam logic [TGT_W-1:0] TGT_CHR_RAM = 3'd4;

   // Mapper register codes, address bits 14:12 of a CPU write at $A000 and up
   localparam logic [2:0] REG_PRG_SELECT = 3'd2;
   localparam logic [2:0] REG_LOW_FD     = 3'd3;
   localparam logic [2:0] REG_LOW_FE     = 3'd4;
   localparam logic [2:0] REG_HIGH_FD    = 3'd5;
   localparam logic [2:0] REG_HIGH_FE    = 3'd6;
   localparam logic [2:0] REG_MIRROR     = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_BANK_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_BANK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_IS_RAM     = 2'd2;

   // Configuration reset values
   localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 5'd8;
   localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 6'd32;

   // Address map
   localparam logic [ADDR_W-1:0] CPU_PRG_RAM_BASE = 16'h6000;
   localparam logic [ADDR_W-1:0] CPU_PRG_ROM_BASE = 16'h8000;
   localparam logic [ADDR_W-1:0] CPU_FIXED_BASE   = 16'hA000;
   localparam logic [ADDR_W-1:0] PPU_HIGH_BASE    = 16'h1000;
   localparam logic [ADDR_W-1:0] PPU_LIMIT        = 16'h2000;

   // Tile fetch triggers
   localparam logic [ADDR_W-1:0] LOW_FD_TRIGGER = 16'h0FD8;
   localparam logic [ADDR_W-1:0] LOW_FE_TRIGGER = 16'h0FE8;
   localparam logic [ADDR_W-1:0] HIGH_FD_FIRST  = 16'h1FD8;
   localparam logic [ADDR_W-1:0] HIGH_FD_LAST   = 16'h1FDF;
   localparam logic [ADDR_W-1:0] HIGH_FE_FIRST  = 16'h1FE8;
   localparam logic [ADDR_W-1:0] HIGH_FE_LAST   = 16'h1FEF;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tlbm_channels_if.sv =====
// Request and response channel interfaces of the tile latch bank mapper.
// Depends on tlbm_pkg for the field widths.
`default_nettype none

interface tlbm_req_if;
   logic                          valid;
   logic                          ready;
   logic [tlbm_pkg::CMD_W-1:0]    command;
   logic [tlbm_pkg::ADDR_W-1:0]   address;
   logic [tlbm_pkg::DATA_W-1:0]   write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface tlbm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tlbm_pkg::TGT_W-1:0]    target;
   logic [tlbm_pkg::OFFSET_W-1:0] mem_offset;
   logic                          mem_write;
   logic                          mirror_horizontal;

   modport source (output valid, target, mem_offset, mem_write, mirror_horizontal,
                   input ready);
   modport sink   (input valid, target, mem_offset, mem_write, mirror_horizontal,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlbm_controller.sv =====
// Sequencing state machine of the tile latch bank mapper: accept, divide, finish.
// Depends on tlbm_pkg for the command and status structs.
`default_nettype none

module tlbm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tlbm_pkg::ctl_cmd_type   ctl_cmd,
   input  tlbm_pkg::dp_status_type dp_status
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DIVIDE = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      ctl_cmd.load   = 1'b0;
      ctl_cmd.step   = 1'b0;
      ctl_cmd.finish = 1'b0;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.load = 1'b1;
               state_in     = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            ctl_cmd.step = 1'b1;
            if (dp_status.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               ctl_cmd.finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl_cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DIVIDE))
      else $error("accepted request did not start the divider");

   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE && !dp_status.div_done) |=> (state_ff == S_DIVIDE))
      else $error("left divide before the last step");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |=> rsp_valid)
      else $error("finished request not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/tlbm_datapath.sv =====
// Datapath of the tile latch bank mapper: configuration, mapper registers, latches,
// restoring remainder unit and response register. Depends on tlbm_pkg.
`default_nettype none

module tlbm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tlbm_pkg::ctl_cmd_type             ctl_cmd,
   output tlbm_pkg::dp_status_type           dp_status,
   input  logic [tlbm_pkg::CMD_W-1:0]        req_command,
   input  logic [tlbm_pkg::ADDR_W-1:0]       req_address,
   input  logic [tlbm_pkg::DATA_W-1:0]       req_write_data,
   input  logic                              csr_write_enable,
   input  logic [tlbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tlbm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic [tlbm_pkg::TGT_W-1:0]        rsp_target,
   output logic [tlbm_pkg::OFFSET_W-1:0]     rsp_mem_offset,
   output logic                              rsp_mem_write,
   output logic                              rsp_mirror_horizontal
);

   // configuration
   logic [tlbm_pkg::PRG_COUNT_W-1:0] prg_count_ff, prg_count_in;
   logic [tlbm_pkg::CHR_COUNT_W-1:0] chr_count_ff, chr_count_in;
   logic                             chr_is_ram_ff, chr_is_ram_in;

   // mapper registers
   logic [tlbm_pkg::PRG_SEL_W-1:0] prg_select_ff, prg_select_in;
   logic [tlbm_pkg::CHR_SEL_W-1:0] low_fd_ff, low_fd_in;
   logic [tlbm_pkg::CHR_SEL_W-1:0] low_fe_ff, low_fe_in;
   logic [tlbm_pkg::CHR_SEL_W-1:0] high_fd_ff, high_fd_in;
   logic [tlbm_pkg::CHR_SEL_W-1:0] high_fe_ff, high_fe_in;
   logic                           low_latch_ff, low_latch_in;
   logic                           high_latch_ff, high_latch_in;
   logic                           mirror_ff, mirror_in;

   // captured request
   logic [tlbm_pkg::CMD_W-1:0]  cmd_ff;
   logic [tlbm_pkg::ADDR_W-1:0] addr_ff;
   logic [tlbm_pkg::DATA_W-1:0] data_ff;

   // remainder unit
   logic [tlbm_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [tlbm_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [tlbm_pkg::DVD_W-1:0]  rem_ff, rem_in;
   logic [tlbm_pkg::STEP_W-1:0] step_ff, step_in;
   logic [tlbm_pkg::DIV_W-1:0]  trial;

   // load side
   logic [tlbm_pkg::PRG_COUNT_W-1:0] prg_total;
   logic [tlbm_pkg::CHR_COUNT_W-1:0] chr_total;
   logic [tlbm_pkg::ADDR_W-1:0]      req_fixed_diff;
   logic [tlbm_pkg::CHR_SEL_W-1:0]   chr_sel;
   logic [tlbm_pkg::DVD_W-1:0]       prg_sel;
   logic                             req_is_ppu;

   // finish side
   logic [tlbm_pkg::ADDR_W-1:0]    fixed_diff;
   logic [1:0]                     slot;
   logic [tlbm_pkg::PRG_SEL_W-1:0] prg_bank;
   logic [tlbm_pkg::TGT_W-1:0]     tgt_in;
   logic [tlbm_pkg::OFFSET_W-1:0]  offset_in;
   logic                           write_in;
   logic [tlbm_pkg::OFFSET_W-1:0]  prg_rom_offset;
   logic [tlbm_pkg::OFFSET_W-1:0]  prg_ram_offset;
   logic [tlbm_pkg::OFFSET_W-1:0]  chr_offset;
   logic [tlbm_pkg::TGT_W-1:0]     chr_target;

   // ---------------- configuration port ----------------
   always_comb begin
      prg_count_in  = prg_count_ff;
      chr_count_in  = chr_count_ff;
      chr_is_ram_in = chr_is_ram_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tlbm_pkg::CSR_PRG_BANK_COUNT:
               prg_count_in = csr_write_data[tlbm_pkg::PRG_COUNT_W-1:0];
            tlbm_pkg::CSR_CHR_BANK_COUNT:
               chr_count_in = csr_write_data[tlbm_pkg::CHR_COUNT_W-1:0];
            tlbm_pkg::CSR_CHR_IS_RAM:
               chr_is_ram_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- operand selection at accept ----------------
   always_comb begin
      if (prg_count_ff == '0) begin
         prg_total = tlbm_pkg::PRG_COUNT_W'(1);
      end else if (prg_count_ff > tlbm_pkg::PRG_COUNT_W'(tlbm_pkg::MAX_PRG_BANKS)) begin
         prg_total = tlbm_pkg::PRG_COUNT_W'(tlbm_pkg::MAX_PRG_BANKS);
      end else begin
         prg_total = prg_count_ff;
      end

      if (chr_is_ram_ff) begin
         chr_total = tlbm_pkg::CHR_COUNT_W'(tlbm_pkg::CHR_RAM_BANKS);
      end else if (chr_count_ff == '0) begin
         chr_total = tlbm_pkg::CHR_COUNT_W'(1);
      end else if (chr_count_ff > tlbm_pkg::CHR_COUNT_W'(tlbm_pkg::MAX_CHR_BANKS)) begin
         chr_total = tlbm_pkg::CHR_COUNT_W'(tlbm_pkg::MAX_CHR_BANKS);
      end else begin
         chr_total = chr_count_ff;
      end
   end

   assign req_is_ppu = req_command inside {tlbm_pkg::CMD_PPU_FETCH, tlbm_pkg::CMD_PPU_PEEK,
                                           tlbm_pkg::CMD_PPU_WRITE};
   assign req_fixed_diff = req_address - tlbm_pkg::CPU_FIXED_BASE;

   always_comb begin
      if (req_address < tlbm_pkg::PPU_HIGH_BASE) begin
         chr_sel = low_latch_ff ? low_fe_ff : low_fd_ff;
      end else begin
         chr_sel = high_latch_ff ? high_fe_ff : high_fd_ff;
      end
      if (req_address < tlbm_pkg::CPU_FIXED_BASE) begin
         prg_sel = tlbm_pkg::DVD_W'(prg_select_ff);
      end else begin
         prg_sel = tlbm_pkg::DVD_W'(req_fixed_diff[14:13]);
      end
   end

   // ---------------- restoring remainder, one bit a step ----------------
   assign trial = {rem_ff, dvd_ff[tlbm_pkg::DVD_W-1]};
   assign dp_status.div_done = (step_ff == tlbm_pkg::STEP_W'(tlbm_pkg::DIV_STEPS - 1));

   always_comb begin
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (ctl_cmd.load) begin
         div_in  = req_is_ppu ? chr_total : tlbm_pkg::DIV_W'(prg_total);
         dvd_in  = req_is_ppu ? chr_sel : prg_sel;
         rem_in  = '0;
         step_in = '0;
      end else if (ctl_cmd.step) begin
         if (trial >= div_ff) begin
            rem_in = tlbm_pkg::DVD_W'(trial - div_ff);
         end else begin
            rem_in = trial[tlbm_pkg::DVD_W-1:0];
         end
         dvd_in  = {dvd_ff[tlbm_pkg::DVD_W-2:0], 1'b0};
         step_in = step_ff + tlbm_pkg::STEP_W'(1);
      end
   end

   // ---------------- result and register update ----------------
   assign fixed_diff = addr_ff - tlbm_pkg::CPU_FIXED_BASE;
   assign slot       = fixed_diff[14:13];

   always_comb begin
      if (addr_ff >= tlbm_pkg::CPU_FIXED_BASE && div_ff >= tlbm_pkg::DIV_W'(3)) begin
         prg_bank = tlbm_pkg::PRG_SEL_W'(div_ff - tlbm_pkg::DIV_W'(3)
                                         + tlbm_pkg::DIV_W'(slot));
      end else begin
         prg_bank = rem_ff[tlbm_pkg::PRG_SEL_W-1:0];
      end
   end

   assign prg_rom_offset = {prg_bank, addr_ff[12:0]};
   assign prg_ram_offset = tlbm_pkg::OFFSET_W'(addr_ff[12:0]);
   assign chr_offset     = {rem_ff, addr_ff[11:0]};
   assign chr_target     = chr_is_ram_ff ? tlbm_pkg::TGT_CHR_RAM : tlbm_pkg::TGT_CHR_ROM;

   always_comb begin
      tgt_in        = tlbm_pkg::TGT_NONE;
      offset_in     = '0;
      write_in      = 1'b0;
      prg_select_in = prg_select_ff;
      low_fd_in     = low_fd_ff;
      low_fe_in     = low_fe_ff;
      high_fd_in    = high_fd_ff;
      high_fe_in    = high_fe_ff;
      low_latch_in  = low_latch_ff;
      high_latch_in = high_latch_ff;
      mirror_in     = mirror_ff;
      case (cmd_ff)
         tlbm_pkg::CMD_CPU_READ: begin
            if (addr_ff >= tlbm_pkg::CPU_PRG_ROM_BASE) begin
               tgt_in    = tlbm_pkg::TGT_PRG_ROM;
               offset_in = prg_rom_offset;
            end else if (addr_ff >= tlbm_pkg::CPU_PRG_RAM_BASE) begin
               tgt_in    = tlbm_pkg::TGT_PRG_RAM;
               offset_in = prg_ram_offset;
            end
         end
         tlbm_pkg::CMD_CPU_WRITE: begin
            if (addr_ff >= tlbm_pkg::CPU_FIXED_BASE) begin
               case (addr_ff[14:12])
                  tlbm_pkg::REG_PRG_SELECT: prg_select_in = data_ff[3:0];
                  tlbm_pkg::REG_LOW_FD:     low_fd_in     = data_ff[4:0];
                  tlbm_pkg::REG_LOW_FE:     low_fe_in     = data_ff[4:0];
                  tlbm_pkg::REG_HIGH_FD:    high_fd_in    = data_ff[4:0];
                  tlbm_pkg::REG_HIGH_FE:    high_fe_in    = data_ff[4:0];
                  tlbm_pkg::REG_MIRROR:     mirror_in     = data_ff[0];
                  default: begin
                  end
               endcase
            end else if (addr_ff >= tlbm_pkg::CPU_PRG_RAM_BASE &&
                         addr_ff < tlbm_pkg::CPU_PRG_ROM_BASE) begin
               tgt_in    = tlbm_pkg::TGT_PRG_RAM;
               offset_in = prg_ram_offset;
               write_in  = 1'b1;
            end
         end
         tlbm_pkg::CMD_PPU_FETCH, tlbm_pkg::CMD_PPU_PEEK: begin
            if (addr_ff < tlbm_pkg::PPU_LIMIT) begin
               tgt_in    = chr_target;
               offset_in = chr_offset;
               // only a real fetch moves a latch; it takes effect on the next one
               if (cmd_ff == tlbm_pkg::CMD_PPU_FETCH) begin
                  if (addr_ff == tlbm_pkg::LOW_FD_TRIGGER) begin
                     low_latch_in = 1'b0;
                  end else if (addr_ff == tlbm_pkg::LOW_FE_TRIGGER) begin
                     low_latch_in = 1'b1;
                  end else if (addr_ff >= tlbm_pkg::HIGH_FD_FIRST &&
                               addr_ff <= tlbm_pkg::HIGH_FD_LAST) begin
                     high_latch_in = 1'b0;
                  end else if (addr_ff >= tlbm_pkg::HIGH_FE_FIRST &&
                               addr_ff <= tlbm_pkg::HIGH_FE_LAST) begin
                     high_latch_in = 1'b1;
                  end
               end
            end
         end
         tlbm_pkg::CMD_PPU_WRITE: begin
            if (addr_ff < tlbm_pkg::PPU_LIMIT && chr_is_ram_ff) begin
               tgt_in    = tlbm_pkg::TGT_CHR_RAM;
               offset_in = chr_offset;
               write_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff  <= tlbm_pkg::PRG_COUNT_RESET;
         chr_count_ff  <= tlbm_pkg::CHR_COUNT_RESET;
         chr_is_ram_ff <= 1'b0;
         prg_select_ff <= '0;
         low_fd_ff     <= '0;
         low_fe_ff     <= '0;
         high_fd_ff    <= '0;
         high_fe_ff    <= '0;
         low_latch_ff  <= 1'b1;
         high_latch_ff <= 1'b1;
         mirror_ff     <= 1'b0;
         step_ff       <= '0;
      end else begin
         prg_count_ff  <= prg_count_in;
         chr_count_ff  <= chr_count_in;
         chr_is_ram_ff <= chr_is_ram_in;
         step_ff       <= step_in;
         if (ctl_cmd.finish) begin
            prg_select_ff <= prg_select_in;
            low_fd_ff     <= low_fd_in;
            low_fe_ff     <= low_fe_in;
            high_fd_ff    <= high_fd_in;
            high_fe_ff    <= high_fe_in;
            low_latch_ff  <= low_latch_in;
            high_latch_ff <= high_latch_in;
            mirror_ff     <= mirror_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (ctl_cmd.load) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
         data_ff <= req_write_data;
      end
      if (ctl_cmd.finish) begin
         rsp_target            <= tgt_in;
         rsp_mem_offset        <= offset_in;
         rsp_mem_write         <= write_in;
         rsp_mirror_horizontal <= mirror_in;
      end
   end

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |-> (tlbm_pkg::DIV_W'(rem_ff) < div_ff))
      else $error("bank remainder not reduced below bank count");

   a_latch_only_on_fetch: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.finish && cmd_ff != tlbm_pkg::CMD_PPU_FETCH)
      |=> ($stable(low_latch_ff) && $stable(high_latch_ff)))
      else $error("latch moved on a request that is not a fetch");

   a_no_target_is_quiet: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |=> (rsp_target != tlbm_pkg::TGT_NONE ||
                          (rsp_mem_offset == '0 && !rsp_mem_write)))
      else $error("unmapped response carries offset or write");

endmodule

`default_nettype wire

// ===== hw/rtl/tile_latch_bank_mapper_core.sv =====
// Top level of the tile latch bank mapper: joins controller and datapath to the channels.
// Depends on tlbm_pkg, tlbm_channels_if, tlbm_controller and tlbm_datapath.
`default_nettype none

// Turns each bus request (CPU read or write, PPU fetch, peek or write) into one response
// naming a target memory, a byte offset into it and a write enable, plus the current
// mirroring. CPU writes at $A000 and up load the program bank, the four pattern bank
// registers and the mirroring; fetches of the trigger tiles flip the pattern latches, and
// the new bank applies from the next fetch on. Each request passes an accept step, five
// steps of the shared restoring remainder unit that reduces the bank number modulo the
// bank count one bit a cycle, and a finish step that builds the response and updates the
// mapper registers. The response sits in an output register, so a new request is
// accepted while the previous response still waits to be taken; only when that register
// is still full at the end of a request does the block hold. Write the configuration
// registers only while no request is in flight.
module tile_latch_bank_mapper_core (
   input  logic                            clock,
   input  logic                            reset,
   tlbm_req_if.sink                        req_ch,
   tlbm_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [tlbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlbm_pkg::CSR_DATA_W-1:0] csr_write_data
);

   tlbm_pkg::ctl_cmd_type   ctl_cmd;
   tlbm_pkg::dp_status_type dp_status;

   // sequence one request at a time and hold the response handshake
   tlbm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status)
   );

   // bank arithmetic, mapper registers and the response register
   tlbm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctl_cmd               (ctl_cmd),
      .dp_status             (dp_status),
      .req_command           (req_ch.command),
      .req_address           (req_ch.address),
      .req_write_data        (req_ch.write_data),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_target            (rsp_ch.target),
      .rsp_mem_offset        (rsp_ch.mem_offset),
      .rsp_mem_write         (rsp_ch.mem_write),
      .rsp_mirror_horizontal (rsp_ch.mirror_horizontal)
   );

endmodule

`default_nettype wire

// ===== dv/tlbm_mapping_checker.sv =====
// Response checker of the tile latch bank mapper: predicts each mapping and compares it.
// Depends on tlbm_pkg and the channel interfaces in tlbm_channels_if.
`default_nettype none

module tlbm_mapping_checker
   import tlbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tlbm_req_if                   req_ch,
   tlbm_rsp_if                   rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count
);

   localparam int PRG_BANK_BYTES = 32'h2000;
   localparam int CHR_BANK_BYTES = 32'h1000;
   localparam int PRG_WINDOW_MASK = 32'h1FFF;
   localparam int CHR_WINDOW_MASK = 32'h0FFF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [TGT_W-1:0]    target;
      logic [OFFSET_W-1:0] offset;
      logic                write;
      logic                mirror;
   } mapping_t;

   // Configuration copy
   logic [PRG_COUNT_W-1:0] prg_count;
   logic [CHR_COUNT_W-1:0] chr_count;
   logic                   chr_ram;

   // Mapper register copy
   logic [PRG_SEL_W-1:0] prg_bank;
   logic [CHR_SEL_W-1:0] low_fd_bank, low_fe_bank, high_fd_bank, high_fe_bank;
   logic                 low_on_fe, high_on_fe;
   logic                 mirror_h;

   mapping_t mapped_q[$];
   mapping_t want, got;
   int       mismatches = 0;
   int       checked = 0;

   function automatic int unsigned bank_limit(int unsigned n, int unsigned max);
      if (n == 0) return 1;
      if (n > max) return max;
      return n;
   endfunction

   function automatic logic [OFFSET_W-1:0] prg_rom_offset(logic [ADDR_W-1:0] addr);
      int unsigned total, bank, slot;
      total = bank_limit(prg_count, MAX_PRG_BANKS);
      if (addr < CPU_FIXED_BASE) begin
         bank = prg_bank % total;
      end else begin
         // with three banks or more, the three top windows hold the last three banks
         slot = 32'(addr - CPU_FIXED_BASE) >> 13;
         bank = (total >= 3) ? total - 3 + slot : slot % total;
      end
      return OFFSET_W'(bank * PRG_BANK_BYTES + (addr & PRG_WINDOW_MASK));
   endfunction

   function automatic logic [OFFSET_W-1:0] chr_offset(logic [ADDR_W-1:0] addr);
      int unsigned total, sel;
      total = chr_ram ? CHR_RAM_BANKS : bank_limit(chr_count, MAX_CHR_BANKS);
      if (addr < PPU_HIGH_BASE) sel = low_on_fe ? low_fe_bank : low_fd_bank;
      else sel = high_on_fe ? high_fe_bank : high_fd_bank;
      return OFFSET_W'((sel % total) * CHR_BANK_BYTES + (addr & CHR_WINDOW_MASK));
   endfunction

   // Map one request and advance the mapper registers.
   function automatic mapping_t map_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] data);
      mapping_t m;
      m = '0;
      case (cmd)
         CMD_CPU_READ: begin
            if (addr >= CPU_PRG_ROM_BASE) begin
               m.target = TGT_PRG_ROM;
               m.offset = prg_rom_offset(addr);
            end else if (addr >= CPU_PRG_RAM_BASE) begin
               m.target = TGT_PRG_RAM;
               m.offset = OFFSET_W'(addr - CPU_PRG_RAM_BASE);
            end
         end
         CMD_CPU_WRITE: begin
            if (addr >= CPU_FIXED_BASE) begin
               case (addr[14:12])
                  REG_PRG_SELECT: prg_bank = data[PRG_SEL_W-1:0];
                  REG_LOW_FD:     low_fd_bank = data[CHR_SEL_W-1:0];
                  REG_LOW_FE:     low_fe_bank = data[CHR_SEL_W-1:0];
                  REG_HIGH_FD:    high_fd_bank = data[CHR_SEL_W-1:0];
                  REG_HIGH_FE:    high_fe_bank = data[CHR_SEL_W-1:0];
                  REG_MIRROR:     mirror_h = data[0];
                  default: ;
               endcase
            end else if (addr >= CPU_PRG_RAM_BASE && addr < CPU_PRG_ROM_BASE) begin
               m.target = TGT_PRG_RAM;
               m.offset = OFFSET_W'(addr - CPU_PRG_RAM_BASE);
               m.write  = 1'b1;
            end
         end
         CMD_PPU_FETCH, CMD_PPU_PEEK: begin
            if (addr < PPU_LIMIT) begin
               m.target = chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
               m.offset = chr_offset(addr);
               // the trigger fetch itself still sees the old bank
               if (cmd == CMD_PPU_FETCH) begin
                  if (addr == LOW_FD_TRIGGER) low_on_fe = 1'b0;
                  else if (addr == LOW_FE_TRIGGER) low_on_fe = 1'b1;
                  else if (addr >= HIGH_FD_FIRST && addr <= HIGH_FD_LAST) high_on_fe = 1'b0;
                  else if (addr >= HIGH_FE_FIRST && addr <= HIGH_FE_LAST) high_on_fe = 1'b1;
               end
            end
         end
         CMD_PPU_WRITE: begin
            if (addr < PPU_LIMIT && chr_ram) begin
               m.target = TGT_CHR_RAM;
               m.offset = chr_offset(addr);
               m.write  = 1'b1;
            end
         end
         default: ;
      endcase
      m.mirror = mirror_h;
      return m;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         prg_count    = PRG_COUNT_RESET;
         chr_count    = CHR_COUNT_RESET;
         chr_ram      = 1'b0;
         prg_bank     = '0;
         low_fd_bank  = '0;
         low_fe_bank  = '0;
         high_fd_bank = '0;
         high_fe_bank = '0;
         low_on_fe    = 1'b1;
         high_on_fe   = 1'b1;
         mirror_h     = 1'b0;
         mapped_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRG_BANK_COUNT: prg_count = csr_write_data[PRG_COUNT_W-1:0];
               CSR_CHR_BANK_COUNT: chr_count = csr_write_data[CHR_COUNT_W-1:0];
               CSR_CHR_IS_RAM:     chr_ram = csr_write_data[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.target = rsp_ch.target;
            got.offset = rsp_ch.mem_offset;
            got.write  = rsp_ch.mem_write;
            got.mirror = rsp_ch.mirror_horizontal;
            if (mapped_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("[%0t] response with no request outstanding: target %0d offset 0x%05h write %0b mirror %0b",
                           $realtime, got.target, got.offset, got.write, got.mirror);
            end else begin
               want = mapped_q.pop_front();
               checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("[%0t] response %0d mismatch: expected target %0d offset 0x%05h write %0b mirror %0b, got target %0d offset 0x%05h write %0b mirror %0b",
                              $realtime, checked, want.target, want.offset, want.write, want.mirror,
                              got.target, got.offset, got.write, got.mirror);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            mapped_q.push_back(map_access(req_ch.command, req_ch.address, req_ch.write_data));
      end
      fail_count    <= mismatches;
      pending_count <= mapped_q.size();
      checked_count <= checked;
   end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Top of the tile latch bank mapper testbench: clock, reset, stimulus and verdict.
// Depends on tlbm_pkg, the channel interfaces, the mapper core and tlbm_mapping_checker.
`default_nettype none

module tb;
   import tlbm_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int SEGMENT_ITEMS = 200;
   localparam int NUM_SEGMENTS  = 8;

   // Index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;
   int unsigned sent_count     = 0;
   int unsigned setting_count  = 0;
   int          fail_count, pending_count, checked_count;

   // Bank count settings per random segment, extremes and out-of-range values included
   int unsigned seg_prg_count[NUM_SEGMENTS] = '{1, 16, 0, 63, 3, 2, 5, 13};
   int unsigned seg_chr_count[NUM_SEGMENTS] = '{1, 32, 0, 63, 7, 2, 17, 31};
   int unsigned seg_chr_ram[NUM_SEGMENTS]   = '{0, 0, 1, 0, 1, 0, 1, 0};

   // Flow-control phases: none, sender idles, receiver stalls, both lightly
   int unsigned phase_idle[4]  = '{0, 84, 0, 17};
   int unsigned phase_stall[4] = '{0, 0, 84, 17};

   tlbm_req_if req_if();
   tlbm_rsp_if rsp_if();

   tile_latch_bank_mapper_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tlbm_mapping_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog: give up if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_count);
         $display("** tile_latch_bank_mapper_core: FAILED **");
         $finish;
      end
   end

   // Response side: stall at the rate of the current phase
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Present one request and hold it until it is taken. Valid stays high on return so that
   // a back-to-back request needs no second assignment in the same step.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.address    <= addr;
      req_if.write_data <= data;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   // Drop valid and hold until every request has its response back.
   task automatic wait_drained;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Load all three configuration registers; call only when drained.
   task automatic write_setting(input int unsigned prg, input int unsigned chr,
                                input int unsigned ram);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PRG_BANK_COUNT;
      csr_write_data   <= CSR_DATA_W'(prg);
      @(posedge clock);
      csr_index        <= CSR_CHR_BANK_COUNT;
      csr_write_data   <= CSR_DATA_W'(chr);
      @(posedge clock);
      csr_index        <= CSR_CHR_IS_RAM;
      csr_write_data   <= CSR_DATA_W'(ram);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   // Pattern-space address biased toward the latch triggers and their neighbors.
   function automatic logic [ADDR_W-1:0] pick_tile_address();
      case ($urandom_range(0, 9))
         0: return LOW_FD_TRIGGER;
         1: return LOW_FE_TRIGGER;
         2: return HIGH_FD_FIRST + ADDR_W'($urandom_range(0, 7));
         3: return HIGH_FE_FIRST + ADDR_W'($urandom_range(0, 7));
         4: begin
            case ($urandom_range(0, 6))
               0: return ADDR_W'(LOW_FD_TRIGGER - 1);
               1: return ADDR_W'(LOW_FD_TRIGGER + 1);
               2: return ADDR_W'(LOW_FE_TRIGGER + 1);
               3: return ADDR_W'(HIGH_FD_FIRST - 1);
               4: return ADDR_W'(HIGH_FD_LAST + 1);
               5: return ADDR_W'(HIGH_FE_FIRST - 1);
               default: return ADDR_W'(HIGH_FE_LAST + 1);
            endcase
         end
         5: return ADDR_W'($urandom);
         default: return ADDR_W'($urandom_range(0, PPU_LIMIT - 1));
      endcase
   endfunction

   // One random request: mostly bank register loads and pattern fetches, peeks and writes across the
   // trigger tiles, with reads, RAM accesses, unmapped accesses and bad commands mixed in.
   task automatic send_random_request;
      logic [DATA_W-1:0] data;
      int unsigned       pick;
      data = DATA_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 16)
         send_request(CMD_CPU_WRITE, CPU_FIXED_BASE + ADDR_W'($urandom_range(0, 16'h5FFF)), data);
      else if (pick < 24)
         send_request(CMD_CPU_WRITE, ADDR_W'($urandom), data);
      else if (pick < 30)
         send_request(CMD_CPU_WRITE,
                      CPU_PRG_RAM_BASE + ADDR_W'($urandom_range(0, 16'h1FFF)), data);
      else if (pick < 37)
         send_request(CMD_CPU_READ, ADDR_W'($urandom), data);
      else if (pick < 44)
         send_request(CMD_CPU_READ,
                      CPU_PRG_RAM_BASE + ADDR_W'($urandom_range(0, 16'h9FFF)), data);
      else if (pick < 70)
         send_request(CMD_PPU_FETCH, pick_tile_address(), data);
      else if (pick < 80)
         send_request(CMD_PPU_PEEK, pick_tile_address(), data);
      else if (pick < 94)
         send_request(CMD_PPU_WRITE, pick_tile_address(), data);
      else
         send_request(CMD_W'(CMD_PPU_WRITE + $urandom_range(1, 3)), ADDR_W'($urandom), data);
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_CPU_READ;
      req_if.address    <= '0;
      req_if.write_data <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_PRG_BANK_COUNT;
      csr_write_data    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset configuration: 8 program banks, 32 pattern banks, ROM.
      send_request(CMD_CPU_READ, CPU_PRG_ROM_BASE, 8'h00);
      send_request(CMD_CPU_READ, 16'hFFFF, 8'h00);
      send_request(CMD_CPU_READ, CPU_PRG_RAM_BASE, 8'h00);
      send_request(CMD_CPU_WRITE, ADDR_W'(CPU_PRG_ROM_BASE - 1), 8'hFF);
      send_request(CMD_CPU_READ, 16'h0000, 8'h00);
      // write into the switchable window is ignored
      send_request(CMD_CPU_WRITE, CPU_PRG_ROM_BASE, 8'h5A);
      // program bank 15 reduces modulo 8
      send_request(CMD_CPU_WRITE, CPU_FIXED_BASE, 8'hFF);
      send_request(CMD_CPU_READ, ADDR_W'(CPU_FIXED_BASE - 1), 8'h00);
      send_request(CMD_CPU_WRITE, 16'hB000, 8'hFF);
      send_request(CMD_CPU_WRITE, 16'hC000, 8'h0A);
      send_request(CMD_CPU_WRITE, 16'hD000, 8'h03);
      send_request(CMD_CPU_WRITE, 16'hE000, 8'h15);
      send_request(CMD_CPU_WRITE, 16'hF000, 8'h01);
      // trigger fetch uses the old bank, the next fetch the new one; a peek moves nothing
      send_request(CMD_PPU_FETCH, 16'h0000, 8'h00);
      send_request(CMD_PPU_FETCH, LOW_FD_TRIGGER, 8'h00);
      send_request(CMD_PPU_FETCH, 16'h0010, 8'h00);
      send_request(CMD_PPU_PEEK, LOW_FE_TRIGGER, 8'h00);
      send_request(CMD_PPU_FETCH, LOW_FE_TRIGGER, 8'h00);
      send_request(CMD_PPU_FETCH, HIGH_FD_LAST, 8'h00);
      send_request(CMD_PPU_FETCH, ADDR_W'(PPU_LIMIT - 1), 8'h00);
      send_request(CMD_PPU_FETCH, HIGH_FE_LAST, 8'h00);
      // pattern ROM write, out-of-range pattern address, unknown command
      send_request(CMD_PPU_WRITE, 16'h0123, 8'hC3);
      send_request(CMD_PPU_FETCH, PPU_LIMIT, 8'h00);
      send_request(CMD_PPU_PEEK, 16'hFFFF, 8'h00);
      send_request(CMD_W'(CMD_PPU_WRITE + 3), 16'h1234, 8'h77);
      send_request(CMD_CPU_WRITE, 16'hFFFF, 8'hFE);
      wait_drained();

      // Unused index, then zero counts with pattern RAM; the setting load follows
      // directly and takes over the write enable
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= 6'h2A;
      @(posedge clock);
      write_setting(0, 0, 1);
      send_request(CMD_PPU_WRITE, ADDR_W'(PPU_LIMIT - 1), 8'hA5);
      send_request(CMD_CPU_READ, 16'hC000, 8'h00);

      // Random segments, each with its own setting and flow-control phase
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         wait_drained();
         write_setting(seg_prg_count[seg], seg_chr_count[seg], seg_chr_ram[seg]);
         send_idle_pct  = phase_idle[seg % 4];
         recv_stall_pct = phase_stall[seg % 4];
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            // hold off halfway until the block has emptied
            if (i == SEGMENT_ITEMS / 2) wait_drained();
            send_random_request();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests over %0d bank settings and four flow-control phases",
               sent_count, setting_count);
      $display("%0d responses checked, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("** tile_latch_bank_mapper_core: PASSED **");
      else
         $display("** tile_latch_bank_mapper_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
